/* hw/rtl/signed_int_to_decimal_ascii_top_defines.svh */
// Assertion macros shared by the RTL of the integer-to-text converter.
// Each macro takes a label, an antecedent and a consequent, and is clocked
// on clk with rst_n as the disable condition.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_TOP_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent.
`define SITDA_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define SITDA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle assertion failed");

`else

`define SITDA_ASSERT_SAME(label, ante, cons)

`define SITDA_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* hw/rtl/sitda_pkg.sv */
package sitda_pkg;

    localparam int VALUE_W  = 32;
    localparam int CHAR_W   = 7;
    localparam int DIGITS   = 10;
    localparam int BITCNT_W = $clog2(VALUE_W);
    localparam int DCNT_W   = $clog2(DIGITS + 1);

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 7'h39;

    // Program steps of the sequencer.
    typedef enum logic [2:0] {
        STEP_IDLE,
        STEP_DABBLE,
        STEP_STRIP,
        STEP_SIGN,
        STEP_DIGIT
    } step_t;

    // Branch conditions selectable by a control word.
    typedef enum logic [2:0] {
        COND_NO_INPUT,
        COND_BITS_LEFT,
        COND_LEAD_ZERO,
        COND_MORE_DIGITS,
        COND_NEVER
    } cond_t;

    typedef struct packed {
        logic  take_input;
        logic  dabble;
        logic  strip;
        logic  emit_sign;
        logic  emit_digit;
        cond_t cond;
        step_t on_true;
        step_t on_false;
    } ctrl_word_t;

    // Read-only control store: one word per step.
    function automatic ctrl_word_t ctrl_rom(input step_t step);
        ctrl_word_t w;
        w = '{take_input: 1'b1, dabble: 1'b0, strip: 1'b0, emit_sign: 1'b0,
              emit_digit: 1'b0, cond: COND_NO_INPUT, on_true: STEP_IDLE,
              on_false: STEP_DABBLE};
        unique case (step)
            STEP_IDLE:
            begin
                w.take_input = 1'b1;
                w.cond       = COND_NO_INPUT;
                w.on_true    = STEP_IDLE;
                w.on_false   = STEP_DABBLE;
            end
            STEP_DABBLE:
            begin
                w.take_input = 1'b0;
                w.dabble     = 1'b1;
                w.cond       = COND_BITS_LEFT;
                w.on_true    = STEP_DABBLE;
                w.on_false   = STEP_STRIP;
            end
            STEP_STRIP:
            begin
                w.take_input = 1'b0;
                w.strip      = 1'b1;
                w.cond       = COND_LEAD_ZERO;
                w.on_true    = STEP_STRIP;
                w.on_false   = STEP_SIGN;
            end
            STEP_SIGN:
            begin
                w.take_input = 1'b0;
                w.emit_sign  = 1'b1;
                w.cond       = COND_NEVER;
                w.on_true    = STEP_SIGN;
                w.on_false   = STEP_DIGIT;
            end
            STEP_DIGIT:
            begin
                w.take_input = 1'b0;
                w.emit_digit = 1'b1;
                w.cond       = COND_MORE_DIGITS;
                w.on_true    = STEP_DIGIT;
                w.on_false   = STEP_IDLE;
            end
            default:
            begin
                w.take_input = 1'b0;
                w.cond       = COND_NEVER;
                w.on_true    = STEP_IDLE;
                w.on_false   = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

/* hw/rtl/signed_int_to_decimal_ascii_top.sv */
// Each input word passes through the idle step, 32 single-bit double-dabble steps, the
// strip steps, the sign step and the digit steps; a new input word is taken only once
// the sequencer is back in the idle step after the last digit of the previous number.
// Characters leave at one per cycle unless the output stalls, which holds the sign or digit step.
// Reset (rst_n, asynchronous, active low) returns the sequencer to its idle step and
// empties the output register; no other state survives between numbers.

`include "signed_int_to_decimal_ascii_top_defines.svh"

module signed_int_to_decimal_ascii_top
    import sitda_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    // Input channel: one signed integer per word.
    input  logic                      value_valid,
    output logic                      value_ready,
    input  logic signed [VALUE_W-1:0] value,
    // Output channel: one ASCII character per word.
    output logic                      char_valid,
    input  logic                      char_ready,
    output logic        [CHAR_W-1:0]  char_code,
    output logic                      last
);

    // The block is a small microcoded engine. A step counter addresses a
    // read-only control store in the package; each control word switches on
    // one datapath action and names a branch condition together with the
    // step to take when it is true and the step to take when it is false.
    //
    // The program is:
    //   IDLE   wait for an input word and load its magnitude and sign.
    //   DABBLE shift the magnitude into a ten-digit BCD register one bit per
    //          cycle, adding three to every digit of five or more first.
    //   STRIP  drop leading zero digits, but always keep the final one.
    //   SIGN   offer a minus sign if the number was negative.
    //   DIGIT  offer the remaining digits, most significant first.

    step_t                step_reg, step_next;
    ctrl_word_t           ctrl;
    logic                 cond_true;
    logic                 out_free;
    logic                 hold;

    logic [VALUE_W-1:0]   mag_reg, mag_next;
    logic                 neg_reg, neg_next;
    logic [BITCNT_W-1:0]  bit_cnt_reg, bit_cnt_next;
    logic [DCNT_W-1:0]    dcnt_reg, dcnt_next;
    logic [3:0]           digit_reg [DIGITS];
    logic [3:0]           digit_next [DIGITS];
    logic [3:0]           digit_adj [DIGITS];
    logic [3:0]           top_digit;

    logic                 out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]    out_char_reg, out_char_next;
    logic                 out_last_reg, out_last_next;

    assign ctrl      = ctrl_rom(step_reg);
    assign top_digit = digit_reg[DIGITS-1];

    // The output register can take a new character word when it is empty or
    // when its present word leaves in this cycle.
    assign out_free = !out_valid_reg || char_ready;

    // An emitting step waits in place while the output register is occupied.
    // The sign step only needs the register when there is a sign to send.
    assign hold = !out_free && (ctrl.emit_digit || (ctrl.emit_sign && neg_reg));

    assign value_ready = ctrl.take_input;

    // Digit correction of the double-dabble step; every digit is independent.
    always_comb
    begin
        for (int i = 0; i < DIGITS; i++)
        begin
            digit_adj[i] = (digit_reg[i] >= 4'd5) ? digit_reg[i] + 4'd3 : digit_reg[i];
        end
    end

    always_comb
    begin
        case (ctrl.cond)
            COND_NO_INPUT:    cond_true = !value_valid;
            COND_BITS_LEFT:   cond_true = bit_cnt_reg != BITCNT_W'(VALUE_W - 1);
            COND_LEAD_ZERO:   cond_true = (top_digit == 4'd0) && (dcnt_reg > DCNT_W'(1));
            COND_MORE_DIGITS: cond_true = dcnt_reg != DCNT_W'(1);
            default:          cond_true = 1'b0;
        endcase
    end

    always_comb
    begin
        step_next    = step_reg;
        mag_next     = mag_reg;
        neg_next     = neg_reg;
        bit_cnt_next = bit_cnt_reg;
        dcnt_next    = dcnt_reg;
        for (int i = 0; i < DIGITS; i++)
        begin
            digit_next[i] = digit_reg[i];
        end

        out_valid_next = out_valid_reg && !char_ready;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;

        if (!hold)
        begin
            step_next = cond_true ? ctrl.on_true : ctrl.on_false;

            // Load: the magnitude of the most negative value is 2^31 as an
            // unsigned number, which the plain two's complement negate gives.
            if (ctrl.take_input && value_valid)
            begin
                neg_next     = value[VALUE_W-1];
                mag_next     = value[VALUE_W-1] ? VALUE_W'(0) - VALUE_W'(value)
                                                : VALUE_W'(value);
                bit_cnt_next = '0;
                dcnt_next    = DCNT_W'(DIGITS);
                for (int i = 0; i < DIGITS; i++)
                begin
                    digit_next[i] = 4'd0;
                end
            end

            if (ctrl.dabble)
            begin
                digit_next[0] = {digit_adj[0][2:0], mag_reg[VALUE_W-1]};
                for (int i = 1; i < DIGITS; i++)
                begin
                    digit_next[i] = {digit_adj[i][2:0], digit_adj[i-1][3]};
                end
                mag_next     = {mag_reg[VALUE_W-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + BITCNT_W'(1);
            end

            // Both stripping a leading zero and sending a digit move the next
            // digit up into the top place.
            if ((ctrl.strip && cond_true) || ctrl.emit_digit)
            begin
                digit_next[0] = 4'd0;
                for (int i = 1; i < DIGITS; i++)
                begin
                    digit_next[i] = digit_reg[i-1];
                end
                dcnt_next = dcnt_reg - DCNT_W'(1);
            end

            // A minus sign is never the final character: a digit follows.
            if (ctrl.emit_sign && neg_reg)
            begin
                out_valid_next = 1'b1;
                out_char_next  = CHAR_MINUS;
                out_last_next  = 1'b0;
            end

            if (ctrl.emit_digit)
            begin
                out_valid_next = 1'b1;
                out_char_next  = CHAR_ZERO + {{(CHAR_W-4){1'b0}}, top_digit};
                out_last_next  = dcnt_reg == DCNT_W'(1);
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= STEP_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath and payload; every field is loaded before it is used.
    always_ff @(posedge clk)
    begin
        mag_reg      <= mag_next;
        neg_reg      <= neg_next;
        bit_cnt_reg  <= bit_cnt_next;
        dcnt_reg     <= dcnt_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
        for (int i = 0; i < DIGITS; i++)
        begin
            digit_reg[i] <= digit_next[i];
        end
    end

    assign char_valid = out_valid_reg;
    assign char_code  = out_char_reg;
    assign last       = out_last_reg;

    // A taken input word always starts the conversion from its first bit.
    `SITDA_ASSERT_NEXT(a_load_starts_dabble, value_valid && value_ready, (step_reg == STEP_DABBLE) && (bit_cnt_reg == '0))

    // The digit count never runs out while digits are being stripped or sent.
    `SITDA_ASSERT_SAME(a_digits_remain, step_reg == STEP_STRIP || step_reg == STEP_DIGIT, dcnt_reg != '0)

    // Only a minus sign or a decimal digit is ever offered.
    `SITDA_ASSERT_SAME(a_char_legal, char_valid, char_code == CHAR_MINUS || (char_code >= CHAR_ZERO && char_code <= CHAR_NINE))

    // The final character of a number is always a digit.
    `SITDA_ASSERT_SAME(a_last_is_digit, char_valid && last, char_code != CHAR_MINUS)

endmodule

/* bench/signed_int_to_decimal_ascii_checker.sv */
`timescale 1ns / 100ps

module signed_int_to_decimal_ascii_checker
    import sitda_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      value_valid,
    input  logic                      value_ready,
    input  logic signed [VALUE_W-1:0] value,
    input  logic                      char_valid,
    input  logic                      char_ready,
    input  logic        [CHAR_W-1:0]  char_code,
    input  logic                      last,
    output int                        mismatch_count,
    output int                        chars_outstanding
);

    localparam int unsigned DECIMAL_BASE = 10;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              is_last;
    } char_word_t;

    char_word_t awaited_chars[$];

    // Appends the decimal text of one integer, most significant character first.
    function automatic void spell_decimal(input logic [VALUE_W-1:0] number);
        logic [VALUE_W-1:0] magnitude;
        logic [3:0]         digit_seq [DIGITS];
        int                 n_digits;
        logic               negative;
        negative  = number[VALUE_W-1];
        magnitude = negative ? (~number + 1'b1) : number;
        n_digits  = 0;
        if (magnitude == '0)
        begin
            awaited_chars.push_back('{code: CHAR_ZERO, is_last: 1'b1});
            return;
        end
        while (magnitude != '0)
        begin
            digit_seq[n_digits] = 4'(magnitude % DECIMAL_BASE);
            magnitude           = magnitude / DECIMAL_BASE;
            n_digits++;
        end
        if (negative)
            awaited_chars.push_back('{code: CHAR_MINUS, is_last: 1'b0});
        for (int i = n_digits - 1; i >= 0; i--)
            awaited_chars.push_back('{code: CHAR_ZERO + CHAR_W'(digit_seq[i]),
                                      is_last: (i == 0)});
    endfunction

    // Both counts are two-state and start from zero.
    always @(posedge clk)
    begin
        char_word_t oldest;
        if (rst_n)
        begin
            if (value_valid && value_ready)
                spell_decimal(value);
            if (char_valid && char_ready)
            begin
                if (awaited_chars.size() == 0)
                begin
                    $error("unexpected character word: char_code %0h last %0b",
                           char_code, last);
                    mismatch_count++;
                end
                else
                begin
                    oldest = awaited_chars.pop_front();
                    if (char_code !== oldest.code)
                    begin
                        $error("char_code: expected %0h, actual %0h", oldest.code, char_code);
                        mismatch_count++;
                    end
                    if (last !== oldest.is_last)
                    begin
                        $error("last: expected %0b, actual %0b", oldest.is_last, last);
                        mismatch_count++;
                    end
                end
            end
            chars_outstanding <= awaited_chars.size();
        end
    end

endmodule

/* bench/tb_signed_int_to_decimal_ascii_top.sv */
`timescale 1ns / 100ps

// Stimulus and verdict for the integer-to-text converter. The checker module
// beside the block watches both channels, works out the characters that each
// accepted integer must produce and compares them as they leave.
module tb_signed_int_to_decimal_ascii_top;
    import sitda_pkg::*;

    localparam int RANDOM_WORDS   = 470;
    localparam int LONG_HOLD_LEN  = 400;
    localparam int DRAIN_CYCLES   = 60;

    // All inputs are known from the very first instant.
    logic                      clk         = 1'b0;
    logic                      rst_n       = 1'b0;
    logic                      value_valid = 1'b0;
    logic                      value_ready;
    logic signed [VALUE_W-1:0] value       = '0;
    logic                      char_valid;
    logic                      char_ready  = 1'b0;
    logic        [CHAR_W-1:0]  char_code;
    logic                      last;

    int mismatch_count;
    int chars_outstanding;
    int words_sent;

    // Set for one long stretch so that the output side backs up into the input.
    logic long_hold = 1'b0;

    always #5 clk = ~clk;

    signed_int_to_decimal_ascii_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .value_valid (value_valid),
        .value_ready (value_ready),
        .value       (value),
        .char_valid  (char_valid),
        .char_ready  (char_ready),
        .char_code   (char_code),
        .last        (last)
    );

    signed_int_to_decimal_ascii_checker checker_i (
        .clk               (clk),
        .rst_n             (rst_n),
        .value_valid       (value_valid),
        .value_ready       (value_ready),
        .value             (value),
        .char_valid        (char_valid),
        .char_ready        (char_ready),
        .char_code         (char_code),
        .last              (last),
        .mismatch_count    (mismatch_count),
        .chars_outstanding (chars_outstanding)
    );

    // Offers one integer at the falling edge and holds it until the block takes
    // it. When called back to back, valid simply stays high and only the
    // payload moves on, so no signal is lowered and raised in the same step.
    task automatic offer_value(input logic [VALUE_W-1:0] number);
        @(negedge clk);
        value_valid <= 1'b1;
        value       <= number;
        do
            @(posedge clk);
        while (!value_ready);
        words_sent++;
    endtask

    // Leaves the input channel idle for a number of cycles; the payload is
    // scrambled meanwhile to show that the block ignores it while valid is low.
    task automatic pause_sender(input int cycles);
        @(negedge clk);
        value_valid <= 1'b0;
        value       <= $urandom();
        repeat (cycles - 1) @(negedge clk);
    endtask

    // Draws a random integer. Most draws pick a digit count first, so that
    // short and long texts are equally common, with a random sign; the rest
    // are raw 32-bit patterns or the awkward corner values.
    function automatic logic [VALUE_W-1:0] pick_value();
        logic [VALUE_W-1:0] number;
        int unsigned        lower;
        int unsigned        upper;
        int unsigned        n_digits;
        int unsigned        choice;
        choice = $urandom_range(0, 9);
        if (choice < 2)
            number = $urandom();
        else if (choice == 2)
        begin
            case ($urandom_range(0, 5))
                0:       number = 32'h8000_0000;
                1:       number = 32'h7FFF_FFFF;
                2:       number = 32'h0000_0000;
                3:       number = 32'hFFFF_FFFF;
                4:       number = 32'h8000_0001;
                default: number = 32'd10;
            endcase
        end
        else
        begin
            n_digits = $urandom_range(1, DIGITS);
            lower    = 1;
            repeat (n_digits - 1) lower = lower * 10;
            upper    = (n_digits == DIGITS) ? 32'h7FFF_FFFF : lower * 10 - 1;
            if (n_digits == 1)
                lower = 0;
            number = $urandom_range(upper, lower);
            if ($urandom_range(0, 1) == 1)
                number = -number;
        end
        return number;
    endfunction

    // Receiver: changes its mood every so often. It may take every word, stall
    // at random, stall most of the time, or drop ready on a fixed rhythm. The
    // long hold overrides all of these.
    initial
    begin
        int unsigned mode;
        int unsigned stretch;
        logic        take;
        forever
        begin
            mode    = $urandom_range(0, 3);
            stretch = $urandom_range(20, 200);
            for (int c = 0; c < stretch; c++)
            begin
                case (mode)
                    0:       take = 1'b1;
                    1:       take = ($urandom_range(0, 1) == 1);
                    2:       take = ($urandom_range(0, 4) == 0);
                    default: take = ((c % 4) != 3);
                endcase
                @(negedge clk);
                char_ready <= take && !long_hold;
            end
        end
    end

    // Once traffic is flowing, the receiver refuses everything for a long
    // stretch while the sender keeps offering; the block fills and must hold
    // value_ready low until the output drains.
    initial
    begin
        wait (words_sent >= 60);
        @(posedge clk);
        long_hold <= 1'b1;
        repeat (LONG_HOLD_LEN) @(posedge clk);
        long_hold <= 1'b0;
    end

    // A hung block ends the run here.
    initial
    begin
        #5_000_000;
        $display("tb_signed_int_to_decimal_ascii_top failed");
        $finish;
    end

    initial
    begin
        logic [VALUE_W-1:0] corner_values [$];
        int                 burst_len;

        // Zero, single digits, the power-of-ten boundaries at 10, 100 and 10^9, both
        // signs, the largest positive value and the most negative value, whose magnitude
        // does not fit in a signed word, plus alternating bit patterns.
        corner_values = {32'd0, 32'd1, -32'sd1, 32'd9, -32'sd9, 32'd10, -32'sd10,
                         32'd99, 32'd100, -32'sd100, 32'd999_999_999,
                         -32'sd999_999_999, 32'd1_000_000_000, -32'sd1_000_000_000,
                         32'd1_234_567_890, 32'h7FFF_FFFF, 32'h8000_0000,
                         32'h8000_0001, 32'h5555_5555, 32'hAAAA_AAAA,
                         32'h0000_FFFF, 32'hFFFF_0000};

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed words go in with short gaps between some of them.
        foreach (corner_values[i])
        begin
            offer_value(corner_values[i]);
            if ($urandom_range(0, 2) == 0)
                pause_sender($urandom_range(1, 6));
        end

        // Random words in bursts. Now and then a long burst or a gapless run
        // keeps the input side busy without a break.
        while (words_sent < corner_values.size() + RANDOM_WORDS)
        begin
            burst_len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                    : $urandom_range(1, 8);
            repeat (burst_len) offer_value(pick_value());
            if ($urandom_range(0, 3) != 0)
                pause_sender($urandom_range(1, 60));
        end
        pause_sender(1);

        // Let every expected character arrive, then watch a while longer for
        // anything the block might still emit unbidden.
        while (chars_outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("tb_signed_int_to_decimal_ascii_top passed");
        else
            $display("tb_signed_int_to_decimal_ascii_top failed");
        $finish;
    end

endmodule
